// File: sv/rdrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrf_pkg
// Shared constants, transfer-code tables and the controller command type for
// the rotating display register file.
// ----------------------------------------------------------------------------
package rdrf_pkg;

   // Register depth and bus geometry
   localparam int DigitCount = 12;
   localparam int BusNibbles = 12;
   localparam int NibW       = 4;
   localparam int DataW      = BusNibbles * NibW;
   localparam int AnnW       = 12;
   localparam int ModeW      = 2;
   localparam int AdrW       = 4;
   localparam int CntW       = $clog2(BusNibbles + 1);

   // Request modes
   localparam logic [ModeW-1:0] ModeRead     = 2'd0;
   localparam logic [ModeW-1:0] ModeWrite    = 2'd1;
   localparam logic [ModeW-1:0] ModeAnnWrite = 2'd2;

   // Special transfer codes
   localparam logic [AdrW-1:0] AdrWholeLast = 4'd2;
   localparam logic [AdrW-1:0] AdrAnnRead   = 4'd5;

   // Register selects
   localparam logic [1:0] RegA = 2'd0;
   localparam logic [1:0] RegB = 2'd1;
   localparam logic [1:0] RegC = 2'd2;

   // Register sets
   localparam logic [2:0] SetA   = 3'd0;
   localparam logic [2:0] SetB   = 3'd1;
   localparam logic [2:0] SetC   = 3'd2;
   localparam logic [2:0] SetAb  = 3'd3;
   localparam logic [2:0] SetAbc = 3'd4;

   // Nibble counts
   localparam logic [CntW-1:0] CntNone  = CntW'(0);
   localparam logic [CntW-1:0] CntOne   = CntW'(1);
   localparam logic [CntW-1:0] CntTwo   = CntW'(2);
   localparam logic [CntW-1:0] CntThree = CntW'(3);
   localparam logic [CntW-1:0] CntWhole = CntW'(BusNibbles);

   typedef struct packed {
      logic [2:0]      set;
      logic            left;
      logic [CntW-1:0] cnt;
   } rdrf_xfer_type;

   // Read decode, indexed by transfer code
   localparam rdrf_xfer_type RdTable [16] = '{
      '{SetA,   1'b0, CntWhole}, '{SetB,   1'b0, CntWhole},
      '{SetC,   1'b0, CntWhole}, '{SetAb,  1'b1, CntWhole},
      '{SetAbc, 1'b1, CntWhole}, '{SetA,   1'b0, CntNone},
      '{SetC,   1'b1, CntOne},   '{SetA,   1'b0, CntOne},
      '{SetB,   1'b0, CntOne},   '{SetC,   1'b0, CntOne},
      '{SetA,   1'b1, CntOne},   '{SetB,   1'b1, CntOne},
      '{SetAb,  1'b0, CntTwo},   '{SetAb,  1'b1, CntTwo},
      '{SetAbc, 1'b0, CntThree}, '{SetAbc, 1'b1, CntThree}
   };

   // Write decode, indexed by transfer code
   localparam rdrf_xfer_type WrTable [16] = '{
      '{SetA,   1'b0, CntWhole}, '{SetB,   1'b0, CntWhole},
      '{SetC,   1'b0, CntWhole}, '{SetAb,  1'b0, CntWhole},
      '{SetAbc, 1'b0, CntWhole}, '{SetAb,  1'b1, CntWhole},
      '{SetAbc, 1'b1, CntWhole}, '{SetA,   1'b0, CntOne},
      '{SetB,   1'b0, CntOne},   '{SetC,   1'b0, CntOne},
      '{SetA,   1'b1, CntOne},   '{SetB,   1'b1, CntOne},
      '{SetAb,  1'b0, CntTwo},   '{SetAb,  1'b1, CntTwo},
      '{SetAbc, 1'b0, CntThree}, '{SetAbc, 1'b1, CntThree}
   };

   // Controller to datapath command
   typedef struct packed {
      logic            start;
      logic            step;
      logic            finish;
      logic            whole;
      logic            wr;
      logic            left;
      logic [1:0]      reg_sel;
      logic [CntW-1:0] nib;
      logic            dch;
      logic            ach;
      logic            sel_ann;
   } rdrf_cmd_type;

endpackage

// File: sv/rotating_display_register_file_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_display_register_file_core
// Three circular display registers (A, B nibble-wide, C bit-wide) with
// pointers and an annunciator word, moved by read and write transfers.
// ----------------------------------------------------------------------------
// The sequencer takes an item, then steps the single store access port once
// per cycle for each nibble the item moves: twelve for whole-register and
// twelve-nibble interleaved transfers, one to three for single and short
// interleaved steps, none for annunciator reads and writes. It then loads the
// response register, waiting while a stalled result still holds it, and only
// then takes the next item. A finished result waits in the response register
// while the next item is taken.
// ----------------------------------------------------------------------------
module rotating_display_register_file_core #(
   parameter int DIGIT_COUNT = rdrf_pkg::DigitCount
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rdrf_pkg::ModeW-1:0]     req_mode,
   input  logic [rdrf_pkg::AdrW-1:0]      req_address,
   input  logic [rdrf_pkg::DataW-1:0]     req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rdrf_pkg::DataW-1:0]     rsp_read_data,
   output logic                           rsp_digits_changed,
   output logic                           rsp_annunciators_changed
);

   rdrf_pkg::rdrf_cmd_type cmd;

   // Sequencer
   rdrf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_address (req_address),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   // Stores and payload
   rdrf_datapath #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .req_write_data           (req_write_data),
      .rsp_read_data            (rsp_read_data),
      .rsp_digits_changed       (rsp_digits_changed),
      .rsp_annunciators_changed (rsp_annunciators_changed)
   );

endmodule

// File: sv/rdrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrf_ctrl
// Sequencer: decodes a request, issues one nibble step per cycle and hands
// the finished result to the response register.
// ----------------------------------------------------------------------------
module rdrf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rdrf_pkg::ModeW-1:0]     req_mode,
   input  logic [rdrf_pkg::AdrW-1:0]      req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rdrf_pkg::rdrf_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_STEP = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [rdrf_pkg::CntW-1:0]     step_ff, step_in;
   logic [rdrf_pkg::CntW-1:0]     cnt_ff, cnt_in;
   logic [2:0]                    set_ff, set_in;
   logic [1:0]                    rsel_ff, rsel_in;
   logic                          left_ff, left_in;
   logic                          wr_ff, wr_in;
   logic                          whole_ff, whole_in;
   logic                          dch_ff, dch_in;
   logic                          ach_ff, ach_in;
   logic                          sel_ann_ff, sel_ann_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   rdrf_pkg::rdrf_xfer_type       xfer;
   logic                          is_rd, is_wr, is_ann_wr;
   logic                          accept, out_free;
   logic [1:0]                    rsel_first, rsel_next;

   // Decode the request on the input port
   always_comb begin
      is_rd     = (req_mode == rdrf_pkg::ModeRead);
      is_wr     = (req_mode == rdrf_pkg::ModeWrite);
      is_ann_wr = (req_mode == rdrf_pkg::ModeAnnWrite);
      xfer      = is_wr ? rdrf_pkg::WrTable[req_address] : rdrf_pkg::RdTable[req_address];
      rsel_first = (xfer.set < rdrf_pkg::SetAb) ? xfer.set[1:0] : rdrf_pkg::RegA;
   end

   // Rotate the register select through the set
   always_comb begin
      rsel_next = rsel_ff;
      if (set_ff == rdrf_pkg::SetAb) begin
         rsel_next = (rsel_ff == rdrf_pkg::RegA) ? rdrf_pkg::RegB : rdrf_pkg::RegA;
      end else if (set_ff == rdrf_pkg::SetAbc) begin
         rsel_next = (rsel_ff == rdrf_pkg::RegC) ? rdrf_pkg::RegA : rsel_ff + 2'd1;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state and command
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      set_in       = set_ff;
      rsel_in      = rsel_ff;
      left_in      = left_ff;
      wr_in        = wr_ff;
      whole_in     = whole_ff;
      dch_in       = dch_ff;
      ach_in       = ach_ff;
      sel_ann_in   = sel_ann_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd          = '0;
      cmd.whole    = whole_ff;
      cmd.wr       = wr_ff;
      cmd.left     = left_ff;
      cmd.reg_sel  = rsel_ff;
      cmd.nib      = step_ff;
      cmd.dch      = dch_ff;
      cmd.ach      = ach_ff;
      cmd.sel_ann  = sel_ann_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start   = 1'b1;
               cmd.reg_sel = rsel_first;
               cnt_in      = (is_rd || is_wr) ? xfer.cnt : rdrf_pkg::CntNone;
               step_in     = rdrf_pkg::CntNone;
               set_in      = xfer.set;
               rsel_in     = rsel_first;
               left_in     = xfer.left;
               wr_in       = is_wr;
               whole_in    = (req_address <= rdrf_pkg::AdrWholeLast);
               dch_in      = is_wr || (is_rd && (req_address > rdrf_pkg::AdrWholeLast)
                                              && (req_address != rdrf_pkg::AdrAnnRead));
               ach_in      = is_ann_wr;
               sel_ann_in  = is_rd && (req_address == rdrf_pkg::AdrAnnRead);
               state_in    = (cnt_in == rdrf_pkg::CntNone) ? S_DONE : S_STEP;
            end
         end
         S_STEP: begin
            // One nibble per cycle
            cmd.step = 1'b1;
            step_in  = step_ff + rdrf_pkg::CntOne;
            rsel_in  = rsel_next;
            if (step_ff == cnt_ff - rdrf_pkg::CntOne) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the response register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         set_ff       <= '0;
         rsel_ff      <= '0;
         left_ff      <= 1'b0;
         wr_ff        <= 1'b0;
         whole_ff     <= 1'b0;
         dch_ff       <= 1'b0;
         ach_ff       <= 1'b0;
         sel_ann_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         set_ff       <= set_in;
         rsel_ff      <= rsel_in;
         left_ff      <= left_in;
         wr_ff        <= wr_in;
         whole_ff     <= whole_in;
         dch_ff       <= dch_in;
         ach_ff       <= ach_in;
         sel_ann_ff   <= sel_ann_in;
      end
   end

endmodule

// File: sv/rdrf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrf_datapath
// Register stores, pointers, annunciator word, data shifter, read
// accumulator and response payload register.
// ----------------------------------------------------------------------------
module rdrf_datapath #(
   parameter int DIGIT_COUNT = rdrf_pkg::DigitCount
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rdrf_pkg::rdrf_cmd_type         cmd,
   input  logic [rdrf_pkg::DataW-1:0]     req_write_data,
   output logic [rdrf_pkg::DataW-1:0]     rsp_read_data,
   output logic                           rsp_digits_changed,
   output logic                           rsp_annunciators_changed
);

   localparam int             PtrW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [PtrW-1:0] LastPos = PtrW'(DIGIT_COUNT - 1);
   localparam int             NibW    = rdrf_pkg::NibW;

   logic [NibW-1:0]            store_a_ff [DIGIT_COUNT];
   logic [NibW-1:0]            store_a_in [DIGIT_COUNT];
   logic [NibW-1:0]            store_b_ff [DIGIT_COUNT];
   logic [NibW-1:0]            store_b_in [DIGIT_COUNT];
   logic                       store_c_ff [DIGIT_COUNT];
   logic                       store_c_in [DIGIT_COUNT];
   logic [PtrW-1:0]            ptr_a_ff, ptr_a_in;
   logic [PtrW-1:0]            ptr_b_ff, ptr_b_in;
   logic [PtrW-1:0]            ptr_c_ff, ptr_c_in;
   logic [PtrW-1:0]            j_ff, j_in;
   logic [rdrf_pkg::AnnW-1:0]  ann_ff, ann_in;
   logic [rdrf_pkg::DataW-1:0] data_ff, data_in;
   logic [rdrf_pkg::DataW-1:0] acc_ff, acc_in;
   logic [rdrf_pkg::DataW-1:0] rdata_ff, rdata_in;
   logic                       dch_ff, dch_in;
   logic                       ach_ff, ach_in;

   logic [PtrW-1:0]            ptr_sel, base, pos_dec, pos_inc, idx, nxt;
   logic                       back;
   logic [NibW-1:0]            rd_val;

   // Pick the pointer of the selected register
   always_comb begin
      case (cmd.reg_sel)
         rdrf_pkg::RegA: ptr_sel = ptr_a_ff;
         rdrf_pkg::RegB: ptr_sel = ptr_b_ff;
         rdrf_pkg::RegC: ptr_sel = ptr_c_ff;
         default:        ptr_sel = ptr_a_ff;
      endcase
   end

   // Position of this step and the position after it
   always_comb begin
      base    = cmd.whole ? j_ff : ptr_sel;
      pos_dec = (base == '0) ? LastPos : base - PtrW'(1);
      pos_inc = (base == LastPos) ? '0 : base + PtrW'(1);
      back    = cmd.whole ? !cmd.wr : cmd.left;
      idx     = back ? pos_dec : base;
      nxt     = back ? pos_dec : pos_inc;
   end

   // Read the entry at the step position
   always_comb begin
      case (cmd.reg_sel)
         rdrf_pkg::RegA: rd_val = store_a_ff[idx];
         rdrf_pkg::RegB: rd_val = store_b_ff[idx];
         rdrf_pkg::RegC: rd_val = {{(NibW-1){1'b0}}, store_c_ff[idx]};
         default:        rd_val = '0;
      endcase
   end

   // Store writes and pointer moves
   always_comb begin
      store_a_in = store_a_ff;
      store_b_in = store_b_ff;
      store_c_in = store_c_ff;
      ptr_a_in   = ptr_a_ff;
      ptr_b_in   = ptr_b_ff;
      ptr_c_in   = ptr_c_ff;
      j_in       = j_ff;
      if (cmd.start) begin
         j_in = ptr_sel;
      end
      if (cmd.step) begin
         if (cmd.wr) begin
            case (cmd.reg_sel)
               rdrf_pkg::RegA: store_a_in[idx] = data_ff[NibW-1:0];
               rdrf_pkg::RegB: store_b_in[idx] = data_ff[NibW-1:0];
               rdrf_pkg::RegC: store_c_in[idx] = data_ff[0];
               default: ;
            endcase
         end
         if (cmd.whole) begin
            j_in = nxt;
         end else begin
            case (cmd.reg_sel)
               rdrf_pkg::RegA: ptr_a_in = nxt;
               rdrf_pkg::RegB: ptr_b_in = nxt;
               rdrf_pkg::RegC: ptr_c_in = nxt;
               default: ;
            endcase
         end
      end
   end

   // Data shifter, read accumulator, annunciator and response payload
   always_comb begin
      data_in  = data_ff;
      acc_in   = acc_ff;
      ann_in   = ann_ff;
      rdata_in = rdata_ff;
      dch_in   = dch_ff;
      ach_in   = ach_ff;
      if (cmd.start) begin
         data_in = req_write_data;
         acc_in  = '0;
      end
      if (cmd.step) begin
         data_in = data_ff >> NibW;
         if (!cmd.wr) begin
            for (int k = 0; k < rdrf_pkg::BusNibbles; k++) begin
               if (cmd.nib == rdrf_pkg::CntW'(k)) begin
                  acc_in[NibW*k +: NibW] = rd_val;
               end
            end
         end
      end
      if (cmd.finish) begin
         if (cmd.ach) begin
            ann_in = data_ff[rdrf_pkg::AnnW-1:0];
         end
         rdata_in = cmd.sel_ann
                  ? {{(rdrf_pkg::DataW-rdrf_pkg::AnnW){1'b0}}, ann_ff}
                  : acc_ff;
         dch_in   = cmd.dch;
         ach_in   = cmd.ach;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            store_a_ff[k] <= '0;
            store_b_ff[k] <= '0;
            store_c_ff[k] <= 1'b0;
         end
         ptr_a_ff <= '0;
         ptr_b_ff <= '0;
         ptr_c_ff <= '0;
         ann_ff   <= '0;
      end else begin
         store_a_ff <= store_a_in;
         store_b_ff <= store_b_in;
         store_c_ff <= store_c_in;
         ptr_a_ff   <= ptr_a_in;
         ptr_b_ff   <= ptr_b_in;
         ptr_c_ff   <= ptr_c_in;
         ann_ff     <= ann_in;
      end
   end

   // Working registers and payload: no reset
   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      data_ff  <= data_in;
      acc_ff   <= acc_in;
      rdata_ff <= rdata_in;
      dch_ff   <= dch_in;
      ach_ff   <= ach_in;
   end

   assign rsp_read_data            = rdata_ff;
   assign rsp_digits_changed       = dch_ff;
   assign rsp_annunciators_changed = ach_ff;

endmodule

// File: sv/rdrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdrf_checker
// Port-level checks on the rotating display register file, bound to the
// top level.
// ----------------------------------------------------------------------------
module rdrf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [rdrf_pkg::DataW-1:0]     rsp_read_data,
   input logic                           rsp_digits_changed,
   input logic                           rsp_annunciators_changed
);

   // Busy straight after a transfer is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after input transfer");

   // No result appears on the cycle after an input transfer
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result raised too early");

   // Annunciator writes touch no digits and return no data
   a_ann_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_annunciators_changed |->
         !rsp_digits_changed && (rsp_read_data == '0))
      else $error("annunciator result carries digit data");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

endmodule

bind rotating_display_register_file_core rdrf_checker u_rdrf_checker (.*);
